// ===== hw/rtl/fpa_pkg.sv =====
// shared types, constants and helpers of the fixed-point alu
package fpa_pkg;

  localparam int unsigned WordW         = 32;
  localparam int unsigned FracW         = 8;
  localparam int unsigned DivBits       = WordW + FracW;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages     = DivBits / StepsPerStage;
  localparam int unsigned ProdW         = 2 * WordW;
  localparam int unsigned MagW          = ProdW - FracW + 1;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);
  localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};

  typedef logic [3:0] op_t;
  localparam op_t OP_ADD      = 4'd0;
  localparam op_t OP_SUB      = 4'd1;
  localparam op_t OP_MUL      = 4'd2;
  localparam op_t OP_DIV      = 4'd3;
  localparam op_t OP_MIN      = 4'd4;
  localparam op_t OP_MAX      = 4'd5;
  localparam op_t OP_INC      = 4'd6;
  localparam op_t OP_DEC      = 4'd7;
  localparam op_t OP_TO_INT   = 4'd8;
  localparam op_t OP_FROM_INT = 4'd9;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_e;

  // classified item handed from the front to the back
  typedef struct packed {
    kind_e            kind;
    logic             neg;
    logic [WordW-1:0] mag_a;
    logic [WordW-1:0] mag_b;
    logic [WordW-1:0] res;
    status_e          status;
    logic             lt;
    logic             eq;
  } work_t;

  typedef struct packed {
    logic [WordW-1:0]   rem;
    logic [DivBits-1:0] num;
  } div_acc_t;

  typedef struct packed {
    kind_e              kind;
    logic               neg;
    logic [WordW-1:0]   den;
    div_acc_t           acc;
    logic [ProdW-1:0]   prod;
    logic [WordW-1:0]   res;
    status_e            status;
    logic               lt;
    logic               eq;
  } stage_t;

  // one restoring division step: quotient bits shift in at the low end of num
  function automatic div_acc_t div_step(div_acc_t acc, logic [WordW-1:0] den);
    logic [WordW:0] trial;
    logic           qbit;
    div_acc_t       nxt;
    trial = {acc.rem, acc.num[DivBits-1]};
    qbit  = (trial >= {1'b0, den});
    if (qbit) begin
      trial = trial - {1'b0, den};
    end
    nxt.rem = trial[WordW-1:0];
    nxt.num = {acc.num[DivBits-2:0], qbit};
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/fpa_if.sv =====
// request and response channel interfaces of the fixed-point alu
interface fpa_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         req_type;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               a_less_than_b;
  logic               a_equals_b;
  logic [1:0]         status_code;
  modport source (output valid, result_value, a_less_than_b, a_equals_b, status_code,
                  input ready);
  modport sink (input valid, result_value, a_less_than_b, a_equals_b, status_code,
                output ready);
endinterface

// ===== hw/rtl/fpa_front.sv =====
// front stage: takes requests, finishes short operations, classifies mul and div
module fpa_front import fpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpa_req_if.sink   req_i,
  output logic      work_valid_o,
  input  logic      work_ready_i,
  output work_t     work_o
);

  logic               valid_q;
  work_t              work_q, work_d;
  logic signed [WordW-1:0] a, b;
  logic [WordW:0]     sum, diff, inc, dec;
  logic [FracW:0]     top_a;
  logic               shl_ovf;

  function automatic logic [WordW-1:0] sat_val(logic [WordW:0] v);
    logic [WordW-1:0] r;
    r = v[WordW-1:0];
    if (v[WordW] != v[WordW-1]) begin
      r = v[WordW] ? WordMin : WordMax;
    end
    return r;
  endfunction

  function automatic status_e sat_st(logic [WordW:0] v);
    return (v[WordW] != v[WordW-1]) ? ST_OVF : ST_OK;
  endfunction

  assign a     = req_i.operand_a;
  assign b     = req_i.operand_b;
  assign sum   = {a[WordW-1], a} + {b[WordW-1], b};
  assign diff  = {a[WordW-1], a} - {b[WordW-1], b};
  assign inc   = {a[WordW-1], a} + (WordW+1)'(1);
  assign dec   = {a[WordW-1], a} - (WordW+1)'(1);
  // shifting left keeps the value only when the dropped bits all match the sign
  assign top_a   = a[WordW-1 -: FracW+1];
  assign shl_ovf = !((&top_a) || !(|top_a));

  always_comb begin
    work_d        = '0;
    work_d.kind   = KIND_SIMPLE;
    work_d.status = ST_OK;
    work_d.lt     = (a < b);
    work_d.eq     = (a == b);
    work_d.neg    = a[WordW-1] ^ b[WordW-1];
    work_d.mag_a  = a[WordW-1] ? (WordW)'(-a) : a;
    work_d.mag_b  = b[WordW-1] ? (WordW)'(-b) : b;
    unique case (req_i.req_type)
      OP_ADD: begin
        work_d.res    = sat_val(sum);
        work_d.status = sat_st(sum);
      end
      OP_SUB: begin
        work_d.res    = sat_val(diff);
        work_d.status = sat_st(diff);
      end
      OP_MUL: work_d.kind = KIND_MUL;
      OP_DIV: begin
        if (b == '0) begin
          work_d.status = ST_DIV0;
        end else begin
          work_d.kind = KIND_DIV;
        end
      end
      OP_MIN: work_d.res = (a < b) ? a : b;
      OP_MAX: work_d.res = (a > b) ? a : b;
      OP_INC: begin
        work_d.res    = sat_val(inc);
        work_d.status = sat_st(inc);
      end
      OP_DEC: begin
        work_d.res    = sat_val(dec);
        work_d.status = sat_st(dec);
      end
      OP_TO_INT: work_d.res = a >>> FracW;
      OP_FROM_INT: begin
        if (shl_ovf) begin
          work_d.res    = a[WordW-1] ? WordMin : WordMax;
          work_d.status = ST_OVF;
        end else begin
          work_d.res = {a[WordW-1-FracW:0], {FracW{1'b0}}};
        end
      end
      default: work_d.res = '0;
    endcase
  end

  assign req_i.ready = !valid_q || work_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      work_q <= work_d;
    end
  end

  assign work_valid_o = valid_q;
  assign work_o       = work_q;

endmodule

// ===== hw/rtl/fpa_queue.sv =====
// short fifo between front and back
module fpa_queue import fpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  work_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output work_t out_data_o
);

  work_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 push, pop;

  assign in_ready_o  = (cnt_q != QueueCntW'(QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue fill count beyond depth");

endmodule

// ===== hw/rtl/fpa_back.sv =====
// back end: multiplier, pipelined divider, rounding, saturation and result register
module fpa_back import fpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      work_valid_i,
  output logic      work_ready_o,
  input  work_t     work_i,
  fpa_rsp_if.source rsp_o
);

  logic              en;
  logic              v_q  [DivStages];
  stage_t            st_q [DivStages];
  stage_t            st_d [DivStages];
  stage_t            load;
  stage_t            last;
  logic              rsp_valid_q;
  logic [WordW-1:0]  res_q, res_d;
  logic              lt_q, eq_q;
  status_e           st_out_q, st_out_d;
  logic [MagW-1:0]   mag;
  logic [DivBits:0]  qd;
  logic [MagW-1:0]   qm;
  logic              rnd_div;

  // the whole chain moves together unless the result register is held
  assign en           = !rsp_valid_q || rsp_o.ready;
  assign work_ready_o = en;

  always_comb begin
    load         = '0;
    load.kind    = work_i.kind;
    load.neg     = work_i.neg;
    load.den     = work_i.mag_b;
    load.acc.rem = '0;
    load.acc.num = (work_i.kind == KIND_DIV) ? {work_i.mag_a, {FracW{1'b0}}} : '0;
    load.prod    = ProdW'(work_i.mag_a) * ProdW'(work_i.mag_b);
    load.res     = work_i.res;
    load.status  = work_i.status;
    load.lt      = work_i.lt;
    load.eq      = work_i.eq;
  end

  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    always_comb begin
      stage_t src;
      src = (g == 0) ? load : st_q[(g == 0) ? 0 : g - 1];
      for (int s = 0; s < StepsPerStage; s++) begin
        src.acc = div_step(src.acc, src.den);
      end
      st_d[g] = src;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en) begin
        v_q[g] <= (g == 0) ? work_valid_i : v_q[(g == 0) ? 0 : g - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[g] <= st_d[g];
      end
    end
  end

  assign last    = st_q[DivStages-1];
  // round half away from zero on the magnitude
  assign rnd_div = ({last.acc.rem, 1'b0} >= {1'b0, last.den});
  assign qd      = {1'b0, last.acc.num} + (DivBits+1)'(rnd_div);
  assign qm      = MagW'(last.prod[ProdW-1:FracW]) + MagW'(last.prod[FracW-1]);

  always_comb begin
    mag      = (last.kind == KIND_MUL) ? qm : MagW'(qd);
    res_d    = last.res;
    st_out_d = last.status;
    if (last.kind != KIND_SIMPLE) begin
      st_out_d = ST_OK;
      if (!last.neg && mag > MagW'(WordMax)) begin
        res_d    = WordMax;
        st_out_d = ST_OVF;
      end else if (last.neg && mag > MagW'(WordMin)) begin
        res_d    = WordMin;
        st_out_d = ST_OVF;
      end else if (last.neg) begin
        res_d = -mag[WordW-1:0];
      end else begin
        res_d = mag[WordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      rsp_valid_q <= v_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q    <= res_d;
      st_out_q <= st_out_d;
      lt_q     <= last.lt;
      eq_q     <= last.eq;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.result_value  = res_q;
  assign rsp_o.a_less_than_b = lt_q;
  assign rsp_o.a_equals_b    = eq_q;
  assign rsp_o.status_code   = st_out_q;

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && st_out_q == ST_DIV0 |-> res_q == '0)
    else $error("division by zero result not zero");

  a_ovf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && st_out_q == ST_OVF |-> res_q == WordMax || res_q == WordMin)
    else $error("overflow result not at a bound");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && eq_q |-> !lt_q)
    else $error("equal and less flags both set");

endmodule

// ===== hw/rtl/fixed_point_alu_core.sv =====
// top level of the signed q24.8 fixed-point alu
// Usage: requests arrive on req_i (req_type, operand_a, operand_b) and results
// leave on rsp_o (result_value, compare flags, status_code); both channels
// transfer on a clock edge where valid and ready are high. Operations are
// add, sub, mul, div, min, max, inc, dec, to_int and from_int; codes 10..15
// give zero with ok status. Products and quotients round half away from zero,
// out-of-range results saturate with overflow status, division by zero gives
// zero with its own status.
// Throughput is one item per cycle for every operation while the receiver
// keeps ready high. From request transfer to result valid an item passes one
// front register, the two-entry queue, twenty divider stages of two restoring
// steps each (40 quotient bits), and the result register. Every operation
// takes the same path so results come out in request order.
// Reset clears the valid bits of all stages and empties the queue. When the
// receiver holds ready low the result register and the divider chain hold;
// the queue and front register keep taking requests until they fill, then
// req_i.ready drops.
module fixed_point_alu_core import fpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpa_req_if.sink   req_i,
  fpa_rsp_if.source rsp_o
);

  logic  f_valid, f_ready;
  work_t f_work;
  logic  q_valid, q_ready;
  work_t q_work;

  fpa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .work_valid_o (f_valid),
    .work_ready_i (f_ready),
    .work_o       (f_work)
  );

  fpa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_work),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_work)
  );

  fpa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (q_valid),
    .work_ready_o (q_ready),
    .work_i       (q_work),
    .rsp_o        (rsp_o)
  );

endmodule
